FILE: src/pla_pkg.sv
package pla_pkg;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_GET     = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_CONNECT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NEW       = 2'd1,
    STAT_REUSE     = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_EVAL,
    S_RESP
  } state_t;

  localparam logic [1:0] CFG_MIN_PORT = 2'd0;
  localparam logic [1:0] CFG_MAX_PORT = 2'd1;
  localparam logic [1:0] CFG_TW_TICKS = 2'd2;

  localparam logic [15:0] MIN_PORT_RST = 16'd1;
  localparam logic [15:0] MAX_PORT_RST = 16'd65535;
  localparam logic [31:0] TW_TICKS_RST = 32'd240;
  localparam logic [15:0] LEASE_MAX    = 16'hFFFF;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] peer;
    logic [15:0] port;
    logic [15:0] start_port;
    logic        connected_flag;
    logic [47:0] now;
  } in_req_t;

  typedef struct packed {
    logic [15:0] granted_port;
    status_t     status;
  } out_res_t;

  // row update controls
  typedef struct packed {
    kind_t       kind;
    logic [31:0] peer;
    logic [47:0] now;
    logic        conn;
    logic        reuse_other;
    logic        reuse_same;
    logic [31:0] tw_ticks;
  } upd_ctl_t;

  typedef struct packed {
    logic    wr_en;
    logic    grant;
    status_t status;
  } upd_res_t;

endpackage

FILE: src/pla_row_mem.sv
module pla_row_mem #(
  parameter int AW = 16,
  parameter int RW = 389
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [RW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [RW-1:0] rdata
);

  logic [RW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pla_row_update.sv
module pla_row_update #(
  parameter int ENTRIES_PER_PORT = 4
) (
  input  logic [ENTRIES_PER_PORT*97:0] row_rd,
  input  pla_pkg::upd_ctl_t            ctl,
  output logic [ENTRIES_PER_PORT*97:0] row_wr,
  output pla_pkg::upd_res_t            res
);

  localparam int E = ENTRIES_PER_PORT;

  logic                 busy_i;
  logic [E-1:0]         val_i;
  logic [E-1:0][31:0]   peer_i;
  logic [E-1:0][15:0]   lea_i;
  logic [E-1:0][47:0]   exp_i;
  logic                 busy_o;
  logic [E-1:0]         val_o;
  logic [E-1:0][31:0]   peer_o;
  logic [E-1:0][15:0]   lea_o;
  logic [E-1:0][47:0]   exp_o;
  logic [E-1:0]         val_p;
  logic [E-1:0]         hit_v;
  logic [48:0]          exp_sum;
  logic [47:0]          exp_sat;

  assign {busy_i, val_i, peer_i, lea_i, exp_i} = row_rd;
  assign row_wr = {busy_o, val_o, peer_o, lea_o, exp_o};

  // saturating expiry
  assign exp_sum = {1'b0, ctl.now} + {17'd0, ctl.tw_ticks};
  assign exp_sat = exp_sum[48] ? '1 : exp_sum[47:0];

  // prune in strict phase, then match peer
  always_comb begin
    for (int e = 0; e < E; e++) begin
      val_p[e] = val_i[e];
      if (ctl.kind == pla_pkg::KIND_GET && !ctl.reuse_other && !ctl.reuse_same &&
          lea_i[e] == 16'd0 && exp_i[e] < ctl.now) begin
        val_p[e] = 1'b0;
      end
      hit_v[e] = val_p[e] && peer_i[e] == ctl.peer;
    end
  end

  always_comb begin
    logic found;
    logic done;
    busy_o = busy_i;
    val_o  = val_p;
    peer_o = peer_i;
    lea_o  = lea_i;
    exp_o  = exp_i;
    res    = '{wr_en: 1'b1, grant: 1'b0, status: pla_pkg::STAT_DONE};
    found  = 1'b0;
    done   = 1'b0;
    case (ctl.kind)
      pla_pkg::KIND_GET: begin
        if (busy_i) begin
          res.wr_en = 1'b0;
        end else if (|hit_v) begin
          if (ctl.reuse_same) begin
            for (int e = 0; e < E; e++) begin
              if (hit_v[e] && !found) begin
                found = 1'b1;
                if (lea_i[e] != pla_pkg::LEASE_MAX) lea_o[e] = lea_i[e] + 16'd1;
              end
            end
            busy_o     = 1'b1;
            res.grant  = 1'b1;
            res.status = pla_pkg::STAT_REUSE;
          end else begin
            busy_o = 1'b0;
          end
        end else begin
          busy_o = 1'b0;
          if (!(|val_p) || ctl.reuse_other) begin
            // first free slot takes the new entry
            for (int e = 0; e < E; e++) begin
              if (!val_p[e] && !done) begin
                done      = 1'b1;
                val_o[e]  = 1'b1;
                peer_o[e] = ctl.peer;
                lea_o[e]  = 16'd1;
                exp_o[e]  = '0;
              end
            end
            if (done) begin
              busy_o     = 1'b1;
              res.grant  = 1'b1;
              res.status = pla_pkg::STAT_NEW;
            end
          end
        end
      end
      pla_pkg::KIND_RELEASE: begin
        for (int e = 0; e < E; e++) begin
          if (hit_v[e] && !found) begin
            found = 1'b1;
            if (lea_i[e] != 16'd0) begin
              lea_o[e] = lea_i[e] - 16'd1;
              exp_o[e] = exp_sat;
            end
          end
        end
        if (!ctl.conn) busy_o = 1'b0;
      end
      pla_pkg::KIND_CONNECT: begin
        busy_o = 1'b0;
      end
      default: begin
        res.wr_en = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/port_lease_allocator_unit.sv
// Channel   Ports                        Moves
// in        in_valid/in_ready/in_req     one request (start, get, release, connect)
// out       out_valid/out_ready/out_res  one result per request
// cfg       cfg_we/cfg_idx/cfg_wdata     range bounds and time-wait delay
//
// Start, and requests that skip the port table, go straight to the result;
// release and connect do a row read, a modify/write, then the result. A get
// reads and evaluates each probed port (a port at or above PORT_COUNT is skipped
// unread), then gives the result; the scan may cover the range up to three times.
// After reset a clearing pass writes PORT_COUNT rows, one per cycle, before
// the first request is taken. One waiting result does not block the next request.
module port_lease_allocator_unit #(
  parameter int PORT_COUNT       = 65536,
  parameter int ENTRIES_PER_PORT = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pla_pkg::in_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output pla_pkg::out_res_t out_res,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata
);

  localparam int AW = $clog2(PORT_COUNT);
  localparam int RW = ENTRIES_PER_PORT * 97 + 1;
  localparam logic [16:0] PORT_LIM = 17'(PORT_COUNT);

  pla_pkg::state_t state_r, state_nxt;

  logic [15:0] min_port_r, max_port_r;
  logic [31:0] tw_ticks_r;
  logic        open_r, open_nxt;
  logic [31:0] speer_r, speer_nxt;
  logic [15:0] first_r, first_nxt, last_r, last_nxt, smin_r, smin_nxt, smax_r, smax_nxt;
  logic        ro_r, ro_nxt, rs_r, rs_nxt;
  pla_pkg::in_req_t req_r, req_nxt;
  logic [AW-1:0] addr_r, addr_nxt, clr_r, clr_nxt;
  pla_pkg::out_res_t res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata, row_rd, row_wr;
  pla_pkg::upd_ctl_t ctl;
  pla_pkg::upd_res_t upd;

  logic        in_fire;
  logic [15:0] lo, hi, cmin, cmax, sp;
  logic [16:0] lp_inc;
  logic [15:0] lp;
  logic        wrap_first, exhaust, port_ok;

  assign in_ready  = (state_r == pla_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // session range from config
  always_comb begin
    lo = (min_port_r > max_port_r) ? max_port_r : min_port_r;
    hi = (min_port_r > max_port_r) ? min_port_r : max_port_r;
    cmin = (lo == 16'd0) ? 16'd1 : lo;
    cmax = (hi == 16'd0) ? 16'd1 : hi;
    sp = in_req.start_port;
    if (sp < cmin) sp = cmin;
    if (sp > cmax) sp = cmax;
  end

  // next probe port
  always_comb begin
    lp_inc     = {1'b0, last_r} + 17'd1;
    wrap_first = 1'b0;
    if (last_r == 16'd0) begin
      lp = first_r;
    end else begin
      if (lp_inc < {1'b0, smin_r} || lp_inc > {1'b0, smax_r}) lp = smin_r;
      else lp = lp_inc[15:0];
      wrap_first = (lp == first_r);
    end
    exhaust = wrap_first && ro_r && rs_r;
    port_ok = {1'b0, lp} < PORT_LIM;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pla_pkg::S_CLEAR: begin
        if (clr_r == AW'(PORT_COUNT - 1)) state_nxt = pla_pkg::S_IDLE;
      end
      pla_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_req.kind == pla_pkg::KIND_START) state_nxt = pla_pkg::S_RESP;
          else if (in_req.kind == pla_pkg::KIND_GET)
            state_nxt = open_r ? pla_pkg::S_PROBE : pla_pkg::S_RESP;
          else if (in_req.port != 16'd0 && {1'b0, in_req.port} < PORT_LIM)
            state_nxt = pla_pkg::S_PROBE;
          else state_nxt = pla_pkg::S_RESP;
        end
      end
      pla_pkg::S_PROBE: begin
        if (req_r.kind != pla_pkg::KIND_GET) state_nxt = pla_pkg::S_EVAL;
        else if (exhaust) state_nxt = pla_pkg::S_RESP;
        else if (port_ok) state_nxt = pla_pkg::S_EVAL;
      end
      pla_pkg::S_EVAL: begin
        if (req_r.kind == pla_pkg::KIND_GET && !upd.grant) state_nxt = pla_pkg::S_PROBE;
        else state_nxt = pla_pkg::S_RESP;
      end
      pla_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = pla_pkg::S_IDLE;
      end
      default: state_nxt = pla_pkg::S_IDLE;
    endcase
  end

  // row update controls
  always_comb begin
    ctl.kind        = req_r.kind;
    ctl.peer        = (req_r.kind == pla_pkg::KIND_GET) ? speer_r : req_r.peer;
    ctl.now         = req_r.now;
    ctl.conn        = req_r.connected_flag;
    ctl.reuse_other = ro_r;
    ctl.reuse_same  = rs_r;
    ctl.tw_ticks    = tw_ticks_r;
  end

  // datapath and memory controls
  always_comb begin
    open_nxt  = open_r;
    speer_nxt = speer_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    smin_nxt  = smin_r;
    smax_nxt  = smax_r;
    ro_nxt    = ro_r;
    rs_nxt    = rs_r;
    req_nxt   = req_r;
    addr_nxt  = addr_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = row_wr;
    mem_re    = 1'b0;
    mem_raddr = lp[AW-1:0];
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      pla_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      pla_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt = in_req;
          res_nxt = '{granted_port: 16'd0, status: pla_pkg::STAT_DONE};
          if (in_req.kind == pla_pkg::KIND_START) begin
            smin_nxt  = cmin;
            smax_nxt  = cmax;
            open_nxt  = 1'b1;
            speer_nxt = in_req.peer;
            first_nxt = sp;
            last_nxt  = 16'd0;
            ro_nxt    = 1'b0;
            rs_nxt    = 1'b0;
          end else if (in_req.kind == pla_pkg::KIND_GET && !open_r) begin
            res_nxt.status = pla_pkg::STAT_EXHAUSTED;
          end
        end
      end
      pla_pkg::S_PROBE: begin
        if (req_r.kind != pla_pkg::KIND_GET) begin
          mem_re    = 1'b1;
          mem_raddr = req_r.port[AW-1:0];
          addr_nxt  = req_r.port[AW-1:0];
        end else begin
          last_nxt = lp;
          if (wrap_first) begin
            if (!ro_r) ro_nxt = 1'b1;
            else if (!rs_r) rs_nxt = 1'b1;
          end
          if (exhaust) begin
            res_nxt.status = pla_pkg::STAT_EXHAUSTED;
          end else if (port_ok) begin
            mem_re   = 1'b1;
            addr_nxt = lp[AW-1:0];
          end
        end
      end
      pla_pkg::S_EVAL: begin
        mem_we = upd.wr_en;
        if (upd.grant) begin
          res_nxt = '{granted_port: last_r, status: upd.status};
        end
      end
      pla_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pla_pkg::S_CLEAR;
      min_port_r  <= pla_pkg::MIN_PORT_RST;
      max_port_r  <= pla_pkg::MAX_PORT_RST;
      tw_ticks_r  <= pla_pkg::TW_TICKS_RST;
      open_r      <= 1'b0;
      speer_r     <= '0;
      first_r     <= '0;
      last_r      <= '0;
      smin_r      <= 16'd1;
      smax_r      <= 16'd1;
      ro_r        <= 1'b0;
      rs_r        <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      speer_r     <= speer_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      smin_r      <= smin_nxt;
      smax_r      <= smax_nxt;
      ro_r        <= ro_nxt;
      rs_r        <= rs_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      // config writes
      if (cfg_we) begin
        case (cfg_idx)
          pla_pkg::CFG_MIN_PORT: min_port_r <= cfg_wdata[15:0];
          pla_pkg::CFG_MAX_PORT: max_port_r <= cfg_wdata[15:0];
          pla_pkg::CFG_TW_TICKS: tw_ticks_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  pla_row_mem #(
    .AW (AW),
    .RW (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (row_rd)
  );

  pla_row_update #(
    .ENTRIES_PER_PORT (ENTRIES_PER_PORT)
  ) u_upd (
    .row_rd (row_rd),
    .ctl    (ctl),
    .row_wr (row_wr),
    .res    (upd)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NPORTS     = 65536;
  localparam int NENT       = 4;
  localparam int CYCLE_CAP  = 3000000;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  pla_pkg::in_req_t   in_req;
  logic      out_valid;
  logic      out_ready;
  pla_pkg::out_res_t  out_res;
  logic      cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_wdata;

  port_lease_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  int unsigned cycles = 0;
  int errors;
  bit hold_req;
  int burst_left;

  pla_pkg::out_res_t results_due[$];

  // allocator mirror: registers and session
  logic [15:0] mir_min, mir_max;
  logic [31:0] mir_tw;
  bit          sess_open;
  logic [31:0] sess_peer;
  int unsigned first_p, last_p, sess_lo, sess_hi;
  bit          relax_other, relax_same;

  // allocator mirror: port table
  bit          port_busy [NPORTS];
  bit          ent_valid [NPORTS*NENT];
  logic [31:0] ent_peer  [NPORTS*NENT];
  logic [15:0] ent_lease [NPORTS*NENT];
  logic [47:0] ent_exp   [NPORTS*NENT];

  // generator state
  int unsigned gen_lo, gen_hi;
  logic [31:0] peer_pool [4];
  logic [47:0] cur_now;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int find_entry(input int unsigned p, input logic [31:0] pe);
    int i;
    for (int e = 0; e < NENT; e++) begin
      i = p * NENT + e;
      if (ent_valid[i] && ent_peer[i] == pe) return i;
    end
    return -1;
  endfunction

  // probe upward from the last probe; three wraps give up
  function automatic void probe_ports(input logic [47:0] now, output logic [15:0] gp,
                                      output pla_pkg::status_t st);
    int unsigned p;
    int hit, free_i, i;
    bit any;
    while (1) begin
      any = 0;
      free_i = -1;
      if (last_p == 0) begin
        last_p = first_p;
      end else begin
        last_p++;
        if (last_p < sess_lo || last_p > sess_hi) last_p = sess_lo;
        if (last_p == first_p) begin
          if (!relax_other) relax_other = 1;
          else if (!relax_same) relax_same = 1;
          else begin
            gp = '0;
            st = pla_pkg::STAT_EXHAUSTED;
            return;
          end
        end
      end
      p = last_p;
      if (p >= NPORTS || port_busy[p]) continue;
      port_busy[p] = 1;
      // strict phase drops expired idle entries
      if (!relax_other && !relax_same) begin
        for (int e = 0; e < NENT; e++) begin
          i = p * NENT + e;
          if (ent_valid[i] && ent_lease[i] == 0 && ent_exp[i] < now) ent_valid[i] = 0;
        end
      end
      hit = find_entry(p, sess_peer);
      if (hit >= 0) begin
        if (relax_same) begin
          if (ent_lease[hit] != pla_pkg::LEASE_MAX) ent_lease[hit]++;
          gp = p[15:0];
          st = pla_pkg::STAT_REUSE;
          return;
        end
      end else begin
        for (int e = 0; e < NENT; e++) begin
          i = p * NENT + e;
          if (ent_valid[i]) any = 1;
          else if (free_i < 0) free_i = i;
        end
        if ((!any || relax_other) && free_i >= 0) begin
          ent_valid[free_i] = 1;
          ent_peer[free_i]  = sess_peer;
          ent_lease[free_i] = 16'd1;
          ent_exp[free_i]   = '0;
          gp = p[15:0];
          st = pla_pkg::STAT_NEW;
          return;
        end
      end
      port_busy[p] = 0;
    end
  endfunction

  function automatic pla_pkg::out_res_t lease_predict(input pla_pkg::in_req_t r);
    pla_pkg::out_res_t res;
    int unsigned lo, hi, sp;
    int i;
    logic [48:0] ex;
    res = '{granted_port: '0, status: pla_pkg::STAT_DONE};
    case (r.kind)
      pla_pkg::KIND_START: begin
        lo = 32'(mir_min);
        hi = 32'(mir_max);
        if (lo > hi) begin
          lo = 32'(mir_max);
          hi = 32'(mir_min);
        end
        sess_lo = (lo < 1) ? 1 : lo;
        sess_hi = (hi < 1) ? 1 : hi;
        sp = 32'(r.start_port);
        if (sp < sess_lo) sp = sess_lo;
        if (sp > sess_hi) sp = sess_hi;
        sess_open   = 1;
        sess_peer   = r.peer;
        first_p     = sp;
        last_p      = 0;
        relax_other = 0;
        relax_same  = 0;
      end
      pla_pkg::KIND_GET: begin
        if (!sess_open) res.status = pla_pkg::STAT_EXHAUSTED;
        else probe_ports(r.now, res.granted_port, res.status);
      end
      pla_pkg::KIND_RELEASE: begin
        if (r.port != 0) begin
          i = find_entry(32'(r.port), r.peer);
          if (i >= 0 && ent_lease[i] != 0) begin
            ex = {1'b0, r.now} + {17'd0, mir_tw};
            ent_lease[i]--;
            ent_exp[i] = ex[48] ? TIME_MAX : ex[47:0];
          end
          if (!r.connected_flag) port_busy[r.port] = 0;
        end
      end
      default: begin
        if (r.port != 0) port_busy[r.port] = 0;
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic pla_pkg::in_req_t mk_req(input pla_pkg::kind_t k, input logic [31:0] pe,
                                              input logic [15:0] po, input logic [15:0] sp,
                                              input bit c, input logic [47:0] n);
    pla_pkg::in_req_t r;
    r.kind = k;
    r.peer = pe;
    r.port = po;
    r.start_port = sp;
    r.connected_flag = c;
    r.now = n;
    return r;
  endfunction

  // one request on the input channel
  task automatic send_req(input pla_pkg::in_req_t r, input bit typed,
                          input pla_pkg::out_res_t want);
    int g;
    pla_pkg::out_res_t p;
    g = (burst_left > 0) ? 0 : pick_gap();
    if (burst_left > 0) burst_left--;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    p = lease_predict(r);
    results_due = {results_due, (typed ? want : p)};
  endtask

  // hold the input until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      pla_pkg::CFG_MIN_PORT: mir_min = val[15:0];
      pla_pkg::CFG_MAX_PORT: mir_max = val[15:0];
      default:               mir_tw  = val;
    endcase
  endtask

  task automatic set_range(input logic [15:0] a, input logic [15:0] b, input logic [31:0] tw);
    drain();
    write_reg(pla_pkg::CFG_MIN_PORT, {16'd0, a});
    write_reg(pla_pkg::CFG_MAX_PORT, {16'd0, b});
    write_reg(pla_pkg::CFG_TW_TICKS, tw);
    gen_lo = (a < b) ? 32'(a) : 32'(b);
    gen_hi = (a < b) ? 32'(b) : 32'(a);
    if (gen_lo < 1) gen_lo = 1;
    if (gen_hi < 1) gen_hi = 1;
  endtask

  function automatic pla_pkg::in_req_t rand_req();
    pla_pkg::in_req_t r;
    int k;
    logic [15:0] po, sp;
    logic [47:0] n;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) n = 48'({$urandom(), $urandom()});
    else begin
      cur_now = cur_now + 48'($urandom_range(0, 300));
      n = cur_now;
    end
    po = 16'($urandom_range(gen_lo, gen_hi));
    if ($urandom_range(0, 9) == 0) po = '0;
    else if ($urandom_range(0, 9) == 0) po = 16'($urandom());
    sp = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(gen_lo, gen_hi)) : 16'($urandom());
    // noise: every field random
    if (k < 8)
      return mk_req(pla_pkg::kind_t'($urandom_range(0, 3)), $urandom(), 16'($urandom()),
                    16'($urandom()), 1'($urandom_range(0, 1)),
                    48'({$urandom(), $urandom()}));
    if (k < 18) r = mk_req(pla_pkg::KIND_START, peer_pool[$urandom_range(0, 3)], po, sp,
                           1'b0, n);
    else if (k < 60)
      r = mk_req(pla_pkg::KIND_GET, $urandom(), po, sp, 1'($urandom_range(0, 1)), n);
    else if (k < 88)
      r = mk_req(pla_pkg::KIND_RELEASE, peer_pool[$urandom_range(0, 3)], po, sp,
                 1'($urandom_range(0, 1)), n);
    else r = mk_req(pla_pkg::KIND_CONNECT, $urandom(), po, sp, 1'($urandom_range(0, 1)), n);
    return r;
  endfunction

  // result side: check and random stalls
  initial begin
    pla_pkg::out_res_t want;
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending", longint'(out_res), 0);
        end else begin
          want = results_due.pop_front();
          if (out_res.granted_port !== want.granted_port)
            report_mismatch("granted_port", longint'(out_res.granted_port),
                            longint'(want.granted_port));
          if (out_res.status !== want.status)
            report_mismatch("status", longint'(out_res.status), longint'(want.status));
        end
      end
      if (hold_req) begin
        hold_req = 0;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall = pick_gap();
      end
    end
  end

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    pla_pkg::in_req_t  req;
    bit          typed;
    pla_pkg::out_res_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_req(input pla_pkg::in_req_t r, input bit typed,
                                  input pla_pkg::out_res_t w);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, val: '0, req: r, typed: typed, want: w};
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] val);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, val: val, req: '0, typed: 1'b0, want: '0};
    dir_rows = {dir_rows, row};
  endfunction

  initial begin
    pla_pkg::out_res_t done_r, exh_r;
    done_r = '{granted_port: '0, status: pla_pkg::STAT_DONE};
    exh_r  = '{granted_port: '0, status: pla_pkg::STAT_EXHAUSTED};
    errors = 0;
    hold_req = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    mir_min = pla_pkg::MIN_PORT_RST;
    mir_max = pla_pkg::MAX_PORT_RST;
    mir_tw  = pla_pkg::TW_TICKS_RST;
    sess_open = 0;
    sess_peer = '0;
    first_p = 0;
    last_p = 0;
    sess_lo = 1;
    sess_hi = 1;
    relax_other = 0;
    relax_same = 0;
    cur_now = 48'd1000;
    gen_lo = 1;
    gen_hi = 65535;

    // directed table: defaults first, then single-port and reversed ranges
    add_req(mk_req(pla_pkg::KIND_GET, 32'd3, 16'd0, 16'd0, 1'b0, 48'd10), 1'b1, exh_r);
    add_req(mk_req(pla_pkg::KIND_RELEASE, 32'd5, 16'd7, 16'd0, 1'b0, 48'd10), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_CONNECT, 32'd0, 16'd0, 16'd0, 1'b1, 48'd10), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_START, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 48'd0), 1'b1,
            done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd20), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd21), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 16'd1, 16'd0, 1'b0, TIME_MAX), 1'b1,
            done_r);
    add_req(mk_req(pla_pkg::KIND_RELEASE, 32'hFFFF_FFFF, 16'd1, 16'd0, 1'b1, TIME_MAX), 1'b1,
            done_r);
    add_req(mk_req(pla_pkg::KIND_CONNECT, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0, 48'd30), 1'b1,
            done_r);
    add_req(mk_req(pla_pkg::KIND_START, 32'd0, 16'd0, 16'hFFFF, 1'b1, 48'd30), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd31), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, TIME_MAX), 1'b0, done_r);
    add_cfg(pla_pkg::CFG_MIN_PORT, 32'd65535);
    add_cfg(pla_pkg::CFG_MAX_PORT, 32'd65535);
    add_cfg(pla_pkg::CFG_TW_TICKS, 32'd0);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd40), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_START, 32'd9, 16'd0, 16'd3, 1'b0, 48'd40), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd41), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd42), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd43), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_CONNECT, 32'd0, 16'hFFFF, 16'd0, 1'b0, 48'd44), 1'b1,
            done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd45), 1'b0, done_r);
    add_cfg(pla_pkg::CFG_MIN_PORT, 32'd20);
    add_cfg(pla_pkg::CFG_MAX_PORT, 32'd0);
    add_cfg(pla_pkg::CFG_TW_TICKS, 32'hFFFF_FFFF);
    add_req(mk_req(pla_pkg::KIND_START, 32'd1, 16'd0, 16'd0, 1'b0, 48'd50), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd51), 1'b0, done_r);
    add_req(mk_req(pla_pkg::KIND_RELEASE, 32'd1, 16'd1, 16'd0, 1'b0, 48'd52), 1'b1, done_r);
    add_req(mk_req(pla_pkg::KIND_GET, 32'd0, 16'd0, 16'd0, 1'b0, 48'd53), 1'b0, done_r);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases, each under its own range and delay
    for (int ph = 0; ph < 19; ph++) begin
      int n_items;
      for (int k = 0; k < 4; k++) peer_pool[k] = $urandom();
      if (ph == 0) set_range(16'd0, 16'hFFFF, 32'd0);
      else if (ph == 1) set_range(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
      else if (ph == 2) set_range(16'hFFFF, 16'hFFFF, $urandom_range(0, 50));
      else begin
        int unsigned a, b;
        a = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 65520);
        b = a + $urandom_range(0, 11);
        if ($urandom_range(0, 1)) set_range(a[15:0], b[15:0], $urandom_range(0, 600));
        else set_range(b[15:0], a[15:0], ($urandom_range(0, 3) == 0) ? $urandom() : 240);
      end
      // long receiver hold while requests keep coming
      if (ph == 5) begin
        hold_req = 1;
        burst_left = 60;
      end
      n_items = (ph < 2) ? 60 : 106;
      // most phases open a session; others keep the old one across the change
      if ($urandom_range(0, 4) != 0)
        send_req(mk_req(pla_pkg::KIND_START, peer_pool[0], 16'd0,
                        16'($urandom_range(gen_lo, gen_hi)), 1'b0, cur_now), 1'b0, '0);
      for (int it = 0; it < n_items; it++) send_req(rand_req(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/pla_pkg.sv
src/pla_row_mem.sv
src/pla_row_update.sv
src/port_lease_allocator_unit.sv
sim/testbench.sv
